FILE: src/eetb_pkg.sv
package eetb_pkg;

  // fixed field widths
  localparam int MODE_W   = 2;
  localparam int TYPE_W   = 4;
  localparam int TICK_W   = 48;
  localparam int DUR_W    = 40;
  localparam int EIDX_W   = 8;
  localparam int STAT_W   = 2;
  localparam int VAL_W    = 48;
  localparam int MASK_W   = 16;
  localparam int END_W    = 49;
  localparam int POS_W    = 50;

  localparam logic [VAL_W-1:0] VAL_MAX     = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] EPOCH_RESET = 48'd1000;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_EPOCH = 1'b0;

  // default parameter values
  localparam int DEF_NUM_TYPES  = 16;
  localparam int DEF_NUM_EPOCHS = 256;
  localparam int DEF_TICK_BITS  = 48;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLIPPED = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TYPE_W-1:0] event_type;
    logic [TICK_W-1:0] start_tick;
    logic [DUR_W-1:0]  duration;
    logic [EIDX_W-1:0] epoch_index;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  bin_ticks;
    logic [VAL_W-1:0]  type_total;
    logic [VAL_W-1:0]  epoch_total;
    logic [MASK_W-1:0] types_used;
    logic [VAL_W-1:0]  epochs_in_use;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              clr_start;
    logic              clr_step;
    logic              ev_book;
    logic              div_go;
    logic              div_sel;
    logic              lo_set;
    logic              nb_add;
    logic              walk_rd;
    logic              walk_wr;
    logic              sum_init;
    logic              sum_issue;
    logic              cnt_set;
    logic              st_we;
    logic [STAT_W-1:0] st_code;
    logic              out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              dur_zero;
    logic              t_ok;
    logic              ep_ok;
    logic              clr_last;
    logic              div_done;
    logic              cur_lt_end;
    logic              ep_full;
    logic              k_done;
    logic              cnt_ok;
  } sts_t;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

endpackage

FILE: src/eetb_chan_if.sv
interface eetb_chan_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: src/eetb_div.sv
module eetb_div #(
  parameter int DIV_W = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [DIV_W-1:0]        dividend,
  input  logic [eetb_pkg::VAL_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_W-1:0]        quot,
  output logic [eetb_pkg::VAL_W-1:0] rem
);
  import eetb_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] dvd_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] dsr_r;

  logic [VAL_W:0]   sh;
  logic [VAL_W:0]   diff;
  logic             ge;

  // one restoring step per cycle, quotient bits shift into the dividend
  always_comb begin
    sh   = {rem_r, dvd_r[DIV_W-1]};
    diff = sh - {1'b0, dsr_r};
    ge   = (sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[VAL_W-1:0] : sh[VAL_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

FILE: src/eetb_dp.sv
module eetb_dp #(
  parameter int NUM_TYPES  = eetb_pkg::DEF_NUM_TYPES,
  parameter int NUM_EPOCHS = eetb_pkg::DEF_NUM_EPOCHS,
  parameter int TICK_BITS  = eetb_pkg::DEF_TICK_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  eetb_pkg::in_item_t         in_data,
  input  eetb_pkg::cmd_t             cmd,
  output eetb_pkg::sts_t             sts,
  input  logic                       cfg_we,
  input  logic [eetb_pkg::VAL_W-1:0] cfg_wdata,
  output logic [eetb_pkg::VAL_W-1:0] epoch_ticks,
  output eetb_pkg::out_item_t        out_data
);
  import eetb_pkg::*;

  localparam int TYPE_BITS = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int EP_BITS   = (NUM_EPOCHS > 1) ? $clog2(NUM_EPOCHS) : 1;
  localparam int AW        = TYPE_BITS + EP_BITS;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int K_W       = TYPE_BITS + 1;
  localparam int EPC_W     = EP_BITS + 1;
  localparam int DIV_W     = (TICK_BITS > VAL_W) ? TICK_BITS : VAL_W;
  localparam int CAP_W     = (TICK_BITS > END_W) ? TICK_BITS : END_W;

  // configuration and store
  logic [VAL_W-1:0]     epoch_r;
  logic [VAL_W-1:0]     tot_r [NUM_TYPES];
  logic [NUM_TYPES-1:0] mask_r;
  logic [TICK_BITS-1:0] late_r;
  logic [VAL_W-1:0]     cnt_r;
  logic                 cnt_ok_r;
  logic [AW-1:0]        clr_addr_r;
  logic [VAL_W-1:0]     bins_r [MEM_DEPTH];
  logic [VAL_W-1:0]     rd_data_r;

  // item and walk state
  in_item_t             item_r;
  logic [END_W-1:0]     end_r;
  logic [POS_W-1:0]     cur_r;
  logic [POS_W-1:0]     nb_r;
  logic [EPC_W-1:0]     ep_r;
  logic [VAL_W-1:0]     share_r;
  logic [K_W-1:0]       k_r;
  logic                 pend_r;
  logic [K_W-1:0]       pend_k_r;
  logic [VAL_W-1:0]     etot_r;
  logic [VAL_W-1:0]     bin_r;
  logic [VAL_W-1:0]     ttot_r;
  logic [STAT_W-1:0]    status_r;
  out_item_t            out_data_r;

  logic [VAL_W-1:0]     eff_epoch;
  logic [TYPE_BITS-1:0] type_idx;
  logic                 t_ok;
  logic                 ep_ok;
  logic [POS_W-1:0]     end_pos;
  logic [POS_W-1:0]     hi_pos;
  logic [CAP_W-1:0]     end_cap;
  logic [CAP_W-1:0]     tick_max;
  logic [TICK_BITS-1:0] end_capped;
  logic [AW-1:0]        walk_addr;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [VAL_W-1:0]     wr_data;
  logic                 wr_en;

  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic [VAL_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_dividend;

  always_comb begin
    eff_epoch  = (epoch_r == '0) ? VAL_W'(1) : epoch_r;
    type_idx   = TYPE_BITS'(item_r.event_type);
    t_ok       = (32'(item_r.event_type) < 32'(NUM_TYPES));
    ep_ok      = (32'(item_r.epoch_index) < 32'(NUM_EPOCHS));
    end_pos    = POS_W'(end_r);
    hi_pos     = (nb_r < end_pos) ? nb_r : end_pos;
    end_cap    = CAP_W'(end_r);
    tick_max   = CAP_W'({TICK_BITS{1'b1}});
    end_capped = TICK_BITS'((end_cap > tick_max) ? tick_max : end_cap);
    walk_addr  = {type_idx, ep_r[EP_BITS-1:0]};
    rd_addr    = cmd.walk_rd ? walk_addr
                             : {k_r[TYPE_BITS-1:0], EP_BITS'(item_r.epoch_index)};
    wr_en      = cmd.clr_step | cmd.walk_wr;
    wr_addr    = cmd.clr_step ? clr_addr_r : walk_addr;
    wr_data    = cmd.clr_step ? '0 : sat_add(rd_data_r, share_r);
    div_dividend = cmd.div_sel ? DIV_W'(late_r) : DIV_W'(item_r.start_tick);
  end

  eetb_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (eff_epoch),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // bin memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bins_r[wr_addr] <= wr_data;
    end
    rd_data_r <= bins_r[rd_addr];
  end

  // configuration, per-type totals, mask, latest end, epoch count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r    <= EPOCH_RESET;
      mask_r     <= '0;
      late_r     <= '0;
      cnt_r      <= '0;
      cnt_ok_r   <= 1'b1;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        tot_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        epoch_r  <= cfg_wdata;
        cnt_ok_r <= 1'b0;
      end
      if (cmd.clr_start) begin
        mask_r     <= '0;
        late_r     <= '0;
        cnt_r      <= '0;
        cnt_ok_r   <= 1'b1;
        clr_addr_r <= '0;
        for (int i = 0; i < NUM_TYPES; i++) begin
          tot_r[i] <= '0;
        end
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.ev_book) begin
        tot_r[type_idx]  <= sat_add(tot_r[type_idx], VAL_W'(item_r.duration));
        mask_r[type_idx] <= 1'b1;
        if (end_capped > late_r) begin
          late_r   <= end_capped;
          cnt_ok_r <= 1'b0;
        end
      end
      if (cmd.cnt_set) begin
        cnt_r    <= VAL_W'(div_quot + DIV_W'(div_rem != '0));
        cnt_ok_r <= 1'b1;
      end
      pend_r <= cmd.sum_issue;
    end
  end

  // item, epoch walk and read-out registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_data;
      end_r    <= END_W'(in_data.start_tick) + END_W'(in_data.duration);
      etot_r   <= '0;
      bin_r    <= '0;
      ttot_r   <= '0;
      status_r <= ST_DONE;
    end
    if (cmd.lo_set) begin
      cur_r <= POS_W'(item_r.start_tick);
      nb_r  <= POS_W'(item_r.start_tick) - POS_W'(div_rem);
      ep_r  <= (div_quot < DIV_W'(NUM_EPOCHS)) ? EPC_W'(div_quot) : EPC_W'(NUM_EPOCHS);
    end
    if (cmd.nb_add) begin
      nb_r <= nb_r + POS_W'(eff_epoch);
    end
    if (cmd.walk_rd) begin
      share_r <= VAL_W'(hi_pos - cur_r);
    end
    if (cmd.walk_wr) begin
      cur_r <= nb_r;
      nb_r  <= nb_r + POS_W'(eff_epoch);
      ep_r  <= ep_r + EPC_W'(1);
    end
    if (cmd.sum_init) begin
      k_r    <= '0;
      ttot_r <= t_ok ? tot_r[type_idx] : '0;
    end
    if (cmd.sum_issue) begin
      k_r      <= k_r + K_W'(1);
      pend_k_r <= k_r;
    end
    if (pend_r) begin
      etot_r <= sat_add(etot_r, rd_data_r);
      if (32'(pend_k_r) == 32'(item_r.event_type)) begin
        bin_r <= rd_data_r;
      end
    end
    if (cmd.st_we) begin
      status_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_data_r.status        <= status_r;
      out_data_r.bin_ticks     <= bin_r;
      out_data_r.type_total    <= ttot_r;
      out_data_r.epoch_total   <= etot_r;
      out_data_r.types_used    <= MASK_W'(mask_r);
      out_data_r.epochs_in_use <= cnt_r;
    end
  end

  always_comb begin
    sts.mode       = item_r.mode;
    sts.dur_zero   = (item_r.duration == '0);
    sts.t_ok       = t_ok;
    sts.ep_ok      = ep_ok;
    sts.clr_last   = &clr_addr_r;
    sts.div_done   = div_done;
    sts.cur_lt_end = (cur_r < end_pos);
    sts.ep_full    = (ep_r == EPC_W'(NUM_EPOCHS));
    sts.k_done     = (k_r == K_W'(NUM_TYPES));
    sts.cnt_ok     = cnt_ok_r;
  end

  assign epoch_ticks = epoch_r;
  assign out_data    = out_data_r;

endmodule

FILE: src/eetb_ctrl.sv
module eetb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  eetb_pkg::sts_t sts,
  output eetb_pkg::cmd_t cmd
);
  import eetb_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_DIVS = 4'd3;
  localparam logic [3:0] S_NB   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_CNT  = 4'd8;
  localparam logic [3:0] S_CDW  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       report_r, report_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    report_nxt    = report_r;
    in_ready      = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          MODE_ADD: begin
            if (sts.dur_zero || !sts.t_ok) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_IGNORED;
              state_nxt   = S_CNT;
            end else begin
              cmd.ev_book = 1'b1;
              cmd.div_go  = 1'b1;
              state_nxt   = S_DIVS;
            end
          end
          MODE_READ: begin
            cmd.sum_init = 1'b1;
            state_nxt    = sts.ep_ok ? S_SUM : S_CNT;
          end
          MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            report_nxt    = 1'b1;
            state_nxt     = S_CLR;
          end
          default: begin
            state_nxt = S_CNT;
          end
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = report_r ? S_CNT : S_IDLE;
        end
      end
      S_DIVS: begin
        if (sts.div_done) begin
          cmd.lo_set = 1'b1;
          state_nxt  = S_NB;
        end
      end
      S_NB: begin
        cmd.nb_add = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (!sts.cur_lt_end) begin
          state_nxt = S_CNT;
        end else if (sts.ep_full) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_CLIPPED;
          state_nxt   = S_CNT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = S_CHK;
      end
      S_SUM: begin
        if (sts.k_done) begin
          state_nxt = S_CNT;
        end else begin
          cmd.sum_issue = 1'b1;
        end
      end
      S_CNT: begin
        if (sts.cnt_ok) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = 1'b1;
          state_nxt   = S_CDW;
        end
      end
      S_CDW: begin
        if (sts.div_done) begin
          cmd.cnt_set = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      report_r    <= (state_nxt == S_CLR) ? report_nxt : 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/event_epoch_time_binner.sv
// add: a DIV_W-bit bit-serial divide, then a bin memory read and write per stored epoch touched;
//   read: the addressed epoch summed over all types; clear: all 2^(clog2 NUM_TYPES +
//   clog2 NUM_EPOCHS) bins zeroed (4096 by default); a further divide follows when the
//   largest end tick grew or the epoch length was rewritten (DIV_W = max(TICK_BITS, 48))
// throughput: one item at a time, next item accepted once the result is registered
// reset: synchronous, then a clearing pass of the bin memory before the first item is taken
module event_epoch_time_binner #(
  parameter int NUM_TYPES  = eetb_pkg::DEF_NUM_TYPES,
  parameter int NUM_EPOCHS = eetb_pkg::DEF_NUM_EPOCHS,
  parameter int TICK_BITS  = eetb_pkg::DEF_TICK_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  eetb_chan_if.sink                       in_ch,
  eetb_chan_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eetb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [eetb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [eetb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import eetb_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             in_ready;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_we;
  logic             reg_hit;
  logic [VAL_W-1:0] epoch_ticks;

  // register index sits in the top address bit, one 64-bit register per 8 bytes
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_EPOCH);
  // write lands on the access phase transfer
  assign cfg_we  = psel & penable & pwrite & pready & reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DATA_W'(epoch_ticks) : '0;

  // sequencer: accepts one item, steps the datapath, loads the result register
  eetb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bins, totals, divider and the result register
  eetb_dp #(
    .NUM_TYPES  (NUM_TYPES),
    .NUM_EPOCHS (NUM_EPOCHS),
    .TICK_BITS  (TICK_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_ch.data),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[VAL_W-1:0]),
    .epoch_ticks (epoch_ticks),
    .out_data    (out_data)
  );

  // a waiting result does not block the next input transfer, but the next result waits in S_FIN until it is taken
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

FILE: src/eetb_chk.sv
module eetb_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input eetb_pkg::out_item_t out_data
);
  import eetb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // clearing pass holds off input right after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready before clearing pass");

  // an empty store has no epochs in use
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.types_used == '0) |-> (out_data.epochs_in_use == '0))
    else $error("epoch count with no types used");

  // ignored and clipped adds report no read fields
  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DONE) |->
      (out_data.bin_ticks == '0) && (out_data.type_total == '0) &&
      (out_data.epoch_total == '0))
    else $error("read fields set on an add result");

endmodule

bind event_epoch_time_binner eetb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

FILE: bench/event_epoch_time_binner_test.sv
module event_epoch_time_binner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import eetb_pkg::*;

  // block geometry at its default parameters
  localparam int NUM_T = DEF_NUM_TYPES;
  localparam int NUM_E = DEF_NUM_EPOCHS;

  // largest end tick the block can hold, and the longest event
  localparam logic [63:0] TICK_LIMIT = (64'd1 << DEF_TICK_BITS) - 64'd1;
  localparam logic [63:0] DUR_MAX    = (64'd1 << DUR_W) - 64'd1;

  // the fourth mode code is unused by the block, nothing changes
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // epoch_ticks lies at 8*i since the register is wider than 32 bits
  localparam logic [CFG_ADDR_W-1:0] EPOCH_ADDR = CFG_ADDR_W'(8 * REG_EPOCH);

  // types hammered in the saturation phase
  localparam logic [TYPE_W-1:0] HOT_TYPE  = 4'd9;
  localparam logic [TYPE_W-1:0] SIDE_TYPE = 4'd10;

  // receiver hold-off that backs the block up into its input
  localparam int LONG_HOLD = 400;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t report;
  } stim_row_t;

  typedef struct {
    logic [VAL_W-1:0] len;
    int               idle;
    int               stall;
    int               items;
    bit               heavy;
    bit               hold;
  } run_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  eetb_chan_if #(.data_t(in_item_t))  in_ch ();
  eetb_chan_if #(.data_t(out_item_t)) out_ch ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  event_epoch_time_binner dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the histogram store
  logic [VAL_W-1:0]  bin_store [NUM_T*NUM_E];
  logic [VAL_W-1:0]  type_sum  [NUM_T];
  logic [MASK_W-1:0] seen_types;
  logic [VAL_W-1:0]  last_end;
  logic [VAL_W-1:0]  epoch_len;

  // reports owed by the block, oldest first
  out_item_t report_queue [$];
  out_item_t want;
  int        mismatches = 0;

  // idling knobs, changed between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold_req  = 1'b0;

  function automatic logic [VAL_W-1:0] add_clamped(input logic [VAL_W-1:0] a,
                                                   input logic [63:0] b);
    logic [63:0] s;
    s = {16'd0, a} + b;
    return (s > {16'd0, VAL_MAX}) ? VAL_MAX : s[VAL_W-1:0];
  endfunction

  function automatic void clear_tally();
    foreach (bin_store[i]) bin_store[i] = '0;
    foreach (type_sum[i]) type_sum[i] = '0;
    seen_types = '0;
    last_end   = '0;
  endfunction

  // effective epoch length, a zero register counts as one tick
  function automatic logic [63:0] epoch_span();
    return (epoch_len == '0) ? 64'd1 : {16'd0, epoch_len};
  endfunction

  // spread one item over the shadow store and work out its report
  function automatic out_item_t tally_item(input in_item_t it);
    out_item_t   r;
    logic [63:0] e, start, dur, stop, ep, lo, hi, kept, cap;
    int          idx;
    r     = '0;
    e     = epoch_span();
    start = {16'd0, it.start_tick};
    dur   = {24'd0, it.duration};
    case (it.mode)
      MODE_ADD: begin
        // type is always in range with 4 bits and 16 types
        if (dur == 64'd0) begin
          r.status = ST_IGNORED;
        end else begin
          stop = start + dur;
          seen_types[it.event_type] = 1'b1;
          type_sum[it.event_type] = add_clamped(type_sum[it.event_type], dur);
          cap = (stop > TICK_LIMIT) ? TICK_LIMIT : stop;
          if (cap > {16'd0, last_end}) last_end = cap[VAL_W-1:0];
          kept = 64'd0;
          // partial first and last epochs, full ones between, nothing past the store
          for (ep = start / e; ep < NUM_E && ep * e < stop; ep++) begin
            lo = ep * e;
            hi = (stop - lo > e) ? lo + e : stop;
            if (lo < start) lo = start;
            idx = int'(it.event_type) * NUM_E + int'(ep);
            bin_store[idx] = add_clamped(bin_store[idx], hi - lo);
            kept += hi - lo;
          end
          r.status = (kept < dur) ? ST_CLIPPED : ST_DONE;
        end
      end
      MODE_READ: begin
        // epoch index always below 256, so the bin is always stored
        idx = int'(it.epoch_index);
        r.type_total = type_sum[it.event_type];
        r.bin_ticks  = bin_store[int'(it.event_type) * NUM_E + idx];
        for (int k = 0; k < NUM_T; k++)
          r.epoch_total = add_clamped(r.epoch_total, {16'd0, bin_store[k * NUM_E + idx]});
      end
      MODE_CLEAR: clear_tally();
      default: ;
    endcase
    cap = {16'd0, last_end};
    r.types_used    = seen_types;
    r.epochs_in_use = VAL_W'(cap / e + ((cap % e) != 64'd0));
    return r;
  endfunction

  function automatic logic [63:0] wide_rand();
    return {16'd0, 16'($urandom), $urandom};
  endfunction

  function automatic in_item_t item_of(input logic [MODE_W-1:0] m, input logic [TYPE_W-1:0] t,
                                       input logic [TICK_W-1:0] s, input logic [DUR_W-1:0] d,
                                       input logic [EIDX_W-1:0] x);
    in_item_t it;
    it.mode        = m;
    it.event_type  = t;
    it.start_tick  = s;
    it.duration    = d;
    it.epoch_index = x;
    return it;
  endfunction

  function automatic out_item_t report_of(input logic [STAT_W-1:0] st,
                                          input logic [VAL_W-1:0] bin,
                                          input logic [VAL_W-1:0] ttot,
                                          input logic [VAL_W-1:0] etot,
                                          input logic [MASK_W-1:0] mask,
                                          input logic [VAL_W-1:0] cnt);
    out_item_t r;
    r.status        = st;
    r.bin_ticks     = bin;
    r.type_total    = ttot;
    r.epoch_total   = etot;
    r.types_used    = mask;
    r.epochs_in_use = cnt;
    return r;
  endfunction

  // general mix, starts placed relative to the current epoch length
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [63:0] e, s, d, ep;
    int          pick;
    e = epoch_span();
    it.event_type  = 4'($urandom_range(15));
    it.epoch_index = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 63)      it.mode = MODE_ADD;
    else if (pick < 93) it.mode = MODE_READ;
    else if (pick < 96) it.mode = MODE_CLEAR;
    else                it.mode = MODE_SPARE;
    // start: mostly inside or just past the stored epochs
    pick = $urandom_range(9);
    ep = $urandom_range(1) ? 64'($urandom_range(15)) : 64'($urandom_range(NUM_E + 3));
    if (pick < 7)       s = ep * e + (wide_rand() % e);
    else if (pick == 7) s = 64'd0;
    else if (pick == 8) s = wide_rand();
    else                s = TICK_LIMIT - 64'($urandom_range(1000));
    if (s > TICK_LIMIT) s = wide_rand();
    // duration: zero, unit, max, within an epoch, across a few epochs
    pick = $urandom_range(19);
    if (pick < 2)       d = 64'd0;
    else if (pick == 2) d = 64'd1;
    else if (pick < 5)  d = DUR_MAX;
    else if (pick < 8)  d = wide_rand();
    else if (pick < 14) d = 64'd1 + wide_rand() % e;
    else                d = 64'd1 + wide_rand() % (64'd4 * e);
    it.start_tick = s[TICK_W-1:0];
    it.duration   = d[DUR_W-1:0];
    return it;
  endfunction

  // long events piled into epoch 0 until bins and totals saturate
  function automatic in_item_t heavy_item(input int n);
    in_item_t it;
    it.mode        = (n % 16 == 15) ? MODE_READ : MODE_ADD;
    it.event_type  = (n % 32 == 7 || n % 32 == 31) ? SIDE_TYPE : HOT_TYPE;
    it.start_tick  = TICK_W'($urandom_range(1000));
    it.duration    = {8'hFF, $urandom};
    it.epoch_index = (n % 64 == 63) ? 8'($urandom_range(255)) : 8'd0;
    return it;
  endfunction

  // offer one item, entered and left at a falling edge
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_report);
    out_item_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken at this edge, book it in the shadow store
    calc = tally_item(it);
    report_queue.push_back(typed ? typed_report : calc);
    @(negedge clk);
  endtask

  // write the epoch length, then read it back
  task automatic write_epoch_len(input logic [VAL_W-1:0] val);
    logic [CFG_DATA_W-1:0] back;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EPOCH_ADDR;
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    epoch_len = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== {16'd0, val}) begin
      $error("epoch_ticks readback mismatch: expected 0x%0h, got 0x%0h", val, back);
      mismatches++;
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus an occasional long hold-off counted here
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every result transfer is matched against the oldest owed report
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (report_queue.size() == 0) begin
        $error("result transfer with no report owed: status 0x%0h", out_ch.data.status);
        mismatches++;
      end else begin
        want = report_queue.pop_front();
        compare_field("status", want.status, out_ch.data.status);
        compare_field("bin_ticks", want.bin_ticks, out_ch.data.bin_ticks);
        compare_field("type_total", want.type_total, out_ch.data.type_total);
        compare_field("epoch_total", want.epoch_total, out_ch.data.epoch_total);
        compare_field("types_used", want.types_used, out_ch.data.types_used);
        compare_field("epochs_in_use", want.epochs_in_use, out_ch.data.epochs_in_use);
      end
    end
  end

  // main sequence
  initial begin
    stim_row_t  plan [$];
    run_phase_t phases [6];

    // every input known from time zero
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    epoch_len   = EPOCH_RESET;
    clear_tally();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset epoch length of 1000 ticks
    // empty store right after reset
    plan.push_back('{item_of(MODE_READ, 4'd0, '0, '0, 8'd0), 1'b1,
                     report_of(ST_DONE, '0, '0, '0, '0, '0)});
    // zero-length event is ignored
    plan.push_back('{item_of(MODE_ADD, 4'd3, '0, '0, 8'd0), 1'b1,
                     report_of(ST_IGNORED, '0, '0, '0, '0, '0)});
    // exactly one full epoch
    plan.push_back('{item_of(MODE_ADD, 4'd3, '0, 40'd1000, 8'd0), 1'b1,
                     report_of(ST_DONE, '0, '0, '0, 16'h0008, 48'd1)});
    plan.push_back('{item_of(MODE_READ, 4'd3, '0, '0, 8'd0), 1'b1,
                     report_of(ST_DONE, 48'd1000, 48'd1000, 48'd1000, 16'h0008, 48'd1)});
    // partial, full, partial epochs for the top type
    plan.push_back('{item_of(MODE_ADD, 4'd15, 48'd1500, 40'd2000, 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd15, '0, '0, 8'd1), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd15, '0, '0, 8'd2), 1'b0, '0});
    // straddles the end of the last stored epoch
    plan.push_back('{item_of(MODE_ADD, 4'd0, 48'd255999, 40'd2, 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd0, '0, '0, 8'd255), 1'b0, '0});
    // longest event from tick zero walks every epoch and clips
    plan.push_back('{item_of(MODE_ADD, 4'd7, '0, DUR_W'(DUR_MAX), 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd7, '0, '0, 8'd128), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd12, '0, '0, 8'd128), 1'b0, '0});
    // last tick plus longest event, end tick caps at the tick limit
    plan.push_back('{item_of(MODE_ADD, 4'd1, VAL_MAX, DUR_W'(DUR_MAX), 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd1, '0, '0, 8'd255), 1'b0, '0});
    // unused mode code with busy fields
    plan.push_back('{item_of(MODE_SPARE, 4'hA, 48'h8000_0000_0001, 40'h80_0000_0001, 8'h80),
                     1'b0, '0});
    // last tick of epoch 0, first tick of epoch 1
    plan.push_back('{item_of(MODE_ADD, 4'd10, 48'd999, 40'd1, 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_ADD, 4'd10, 48'd1000, 40'd1, 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd10, 48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 8'd0),
                     1'b0, '0});
    // clear empties everything
    plan.push_back('{item_of(MODE_CLEAR, 4'd5, 48'h5555_5555_5555, 40'hAA_AAAA_AAAA, 8'h7F),
                     1'b1, report_of(ST_DONE, '0, '0, '0, '0, '0)});
    plan.push_back('{item_of(MODE_READ, 4'd7, '0, '0, 8'd128), 1'b1,
                     report_of(ST_DONE, '0, '0, '0, '0, '0)});
    plan.push_back('{item_of(MODE_ADD, 4'd5, '0, DUR_W'(DUR_MAX), 8'd0), 1'b0, '0});
    plan.push_back('{item_of(MODE_READ, 4'd5, 48'h5555_5555_5555, 40'hAA_AAAA_AAAA, 8'd0),
                     1'b0, '0});

    foreach (plan[i]) offer_item(plan[i].item, plan[i].typed, plan[i].report);
    in_ch.valid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk);

    // random phases: epoch length, sender idle %, receiver stall %, items
    phases[0] = '{EPOCH_RESET, 0, 0, 110, 1'b0, 1'b0};
    phases[1] = '{48'd1, 88, 0, 60, 1'b0, 1'b0};
    phases[2] = '{VAL_MAX, 0, 88, 300, 1'b1, 1'b0};
    phases[3] = '{48'd0, 13, 13, 60, 1'b0, 1'b1};
    phases[4] = '{VAL_W'($urandom_range(200000, 2)), 13, 13, 70, 1'b0, 1'b0};
    phases[5] = '{VAL_W'(wide_rand()), 0, 0, 50, 1'b0, 1'b0};

    foreach (phases[p]) begin
      // block is idle here, every owed report has arrived
      write_epoch_len(phases[p].len);
      send_idle_pct  = phases[p].idle;
      recv_stall_pct = phases[p].stall;
      // long receiver hold-off while the sender keeps offering
      if (phases[p].hold) long_hold_req = 1'b1;
      for (int n = 0; n < phases[p].items; n++)
        offer_item(phases[p].heavy ? heavy_item(n) : random_item(), 1'b0, '0);
      in_ch.valid <= 1'b0;
      while (report_queue.size() != 0) @(posedge clk);
    end

    // room for any stray result after the last one
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("event_epoch_time_binner verification clean");
    end else begin
      $display("event_epoch_time_binner verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("event_epoch_time_binner verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/eetb_pkg.sv
src/eetb_chan_if.sv
src/eetb_div.sv
src/eetb_dp.sv
src/eetb_ctrl.sv
src/event_epoch_time_binner.sv
src/eetb_chk.sv
bench/event_epoch_time_binner_test.sv
